### rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types, constants and functions of the date arithmetic block
// Field widths, request codes, register indexes, payload structs and the
// calendar helpers used by the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package gda_pkg;

   // field widths
   localparam int YEAR_BITS   = 16;
   localparam int AMOUNT_BITS = 16;
   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int MOD_W       = 9;   // year modulo 400
   localparam int DSR_W       = 9;   // divisor width (12 or 400)

   // divider dividend: a year or a month total, whichever is wider
   localparam int DIV_W = (YEAR_BITS > AMOUNT_BITS + 1) ? YEAR_BITS : AMOUNT_BITS + 1;
   localparam int SUM_W = DIV_W + 1;
   // remaining day count: must hold one full 400-year cycle of days
   localparam int CNT_W = (AMOUNT_BITS > 18) ? AMOUNT_BITS : 18;

   localparam logic [CNT_W-1:0] CYCLE_DAYS = CNT_W'(146097);
   localparam int CYCLE_YEARS = 400;

   localparam longint unsigned YEAR_MAX_L = (64'd1 << YEAR_BITS) - 64'd1;
   localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;
   localparam logic [MOD_W-1:0] YEAR_MAX_MOD = MOD_W'(YEAR_MAX_L % 400);

   localparam logic [DSR_W-1:0] DIVISOR_400 = DSR_W'(400);
   localparam logic [DSR_W-1:0] DIVISOR_12  = DSR_W'(12);

   // reciprocal constants: exact quotient for every DIV_W-bit dividend
   localparam int RECIP_W   = DIV_W + 1;
   localparam int PROD_W    = DIV_W + RECIP_W;
   localparam int SHIFT_400 = DIV_W + 9;
   localparam int SHIFT_12  = DIV_W + 4;
   localparam logic [RECIP_W-1:0] RECIP_400 =
      RECIP_W'(((64'd1 << SHIFT_400) + 64'd399) / 64'd400);
   localparam logic [RECIP_W-1:0] RECIP_12 =
      RECIP_W'(((64'd1 << SHIFT_12) + 64'd11) / 64'd12);

   // reset date
   localparam logic [DAY_W-1:0]     RESET_DAY   = DAY_W'(22);
   localparam logic [MONTH_W-1:0]   RESET_MONTH = MONTH_W'(12);
   localparam int                   RESET_YEAR_I = 2015;
   localparam logic [YEAR_BITS-1:0] RESET_YEAR  = YEAR_BITS'(RESET_YEAR_I);
   localparam logic [MOD_W-1:0]     RESET_MOD   = MOD_W'(RESET_YEAR_I % 400);

   localparam logic [DAY_W-1:0]   LAST_DAY    = DAY_W'(31);
   localparam logic [MONTH_W-1:0] DECEMBER    = MONTH_W'(12);
   localparam logic [MONTH_W-1:0] JANUARY     = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] FEBRUARY    = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MARCH       = MONTH_W'(3);
   localparam logic [DAY_W-1:0]   LEAP_DAY    = DAY_W'(29);

   // request codes
   localparam logic [1:0] REQ_SET    = 2'd0;
   localparam logic [1:0] REQ_DAYS   = 2'd1;
   localparam logic [1:0] REQ_MONTHS = 2'd2;
   localparam logic [1:0] REQ_YEARS  = 2'd3;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = YEAR_BITS;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_DAY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_MONTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_YEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [DAY_W-1:0]       day_in;
      logic [MONTH_W-1:0]     month_in;
      logic [YEAR_BITS-1:0]   year_in;
      logic [AMOUNT_BITS-1:0] amount;
   } req_payload_type;

   typedef struct packed {
      logic [DAY_W-1:0]     day_out;
      logic [MONTH_W-1:0]   month_out;
      logic [YEAR_BITS-1:0] year_out;
      logic                 bad_date;
      logic                 year_overflow;
   } rsp_payload_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DSR_W-1:0] remainder;
   } div_result_type;

   // leap year from year mod 400: divisible by 4, not a plain century
   function automatic logic is_leap(input logic [MOD_W-1:0] ymod);
      is_leap = (ymod[1:0] == 2'b00) && (ymod != MOD_W'(100)) &&
                (ymod != MOD_W'(200)) && (ymod != MOD_W'(300));
   endfunction

   // days in a month; zero for a month code outside 1..12
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      unique case (m) inside
         4'd2:                               month_len = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11:            month_len = DAY_W'(30);
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
         4'd12:                              month_len = DAY_W'(31);
         default:                            month_len = '0;
      endcase
   endfunction

   // year mod 400 after one more year
   function automatic logic [MOD_W-1:0] mod_next(input logic [MOD_W-1:0] ymod);
      mod_next = (ymod == MOD_W'(CYCLE_YEARS - 1)) ? '0 : ymod + MOD_W'(1);
   endfunction

endpackage

### rtl/gda_div.sv
// ----------------------------------------------------------------------------
// gda_div: shared constant divider
// Divides a DIV_W-bit value by 12 or 400 through a reciprocal multiply, then
// forms the remainder by multiply back and subtract. Gives quotient and
// remainder with a done pulse once operands, quotient and remainder are registered in turn.
// ----------------------------------------------------------------------------
module gda_div
   import gda_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output div_result_type   result
);

   logic               quo_pend_ff, quo_pend_in;
   logic               rem_pend_ff, rem_pend_in;
   logic               done_ff, done_in;
   logic [DIV_W-1:0]   num_ff, num_in;
   logic [DSR_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DSR_W-1:0]   rem_ff, rem_in;

   logic               by_12;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0]  product;
   logic [DIV_W-1:0]   quo_calc;
   logic [DIV_W-1:0]   quo_times_dsr;
   logic [DIV_W-1:0]   rem_calc;

   // quotient from the reciprocal, remainder from the multiply back
   assign by_12         = (dsr_ff == DIVISOR_12);
   assign recip         = by_12 ? RECIP_12 : RECIP_400;
   assign product       = PROD_W'(num_ff) * PROD_W'(recip);
   assign quo_calc      = by_12 ? DIV_W'(product >> SHIFT_12) : DIV_W'(product >> SHIFT_400);
   assign quo_times_dsr = by_12 ? quo_ff * DIV_W'(DIVISOR_12) : quo_ff * DIV_W'(DIVISOR_400);
   assign rem_calc      = num_ff - quo_times_dsr;

   // latch operands, then quotient, then remainder
   always_comb begin
      quo_pend_in = 1'b0;
      rem_pend_in = 1'b0;
      done_in     = 1'b0;
      num_in      = num_ff;
      dsr_in      = dsr_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      if (quo_pend_ff) begin
         quo_in      = quo_calc;
         rem_pend_in = 1'b1;
      end else if (rem_pend_ff) begin
         rem_in  = rem_calc[DSR_W-1:0];
         done_in = 1'b1;
      end else if (start) begin
         num_in      = dividend;
         dsr_in      = divisor;
         quo_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_pend_ff <= 1'b0;
         rem_pend_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         quo_pend_ff <= quo_pend_in;
         rem_pend_ff <= rem_pend_in;
         done_ff     <= done_in;
      end
      num_ff <= num_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

### rtl/gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic: Gregorian date register with set and add requests
// Holds one valid date. Set requests validate and load a date; add requests
// move it by days, months or years, saturating at the last representable day.
//
//   Channel   Ports                        Moves
//   request   req_valid/req_ready/req_data one set or add transaction
//   response  rsp_valid/rsp_ready/rsp_data date after the transaction, flags
//   config    csr_we/csr_index/csr_wdata   write of a default date field
//
// A set or an in-range add of years makes one mod-400 pass of the shared divider; a set
// with a zero year, month or day or a month above 12, or a zero add, skips the divider.
// Add months divides by 12, then takes the new year mod 400. Add days skips
// whole 400-year cycles, then walks one month per cycle. The request side is
// ready only while the sequencer is idle; a finished response waits in its
// own register, so the next transaction can start, and only a response still
// waiting there at the next finish stalls it.
// Reset is synchronous and sets the date to 22 December 2015.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic
   import gda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SETMOD = 4'd1;
   localparam logic [3:0] ST_CYCLE  = 4'd2;
   localparam logic [3:0] ST_MONTH  = 4'd3;
   localparam logic [3:0] ST_MDIV   = 4'd4;
   localparam logic [3:0] ST_MMOD   = 4'd5;
   localparam logic [3:0] ST_YMOD   = 4'd6;
   localparam logic [3:0] ST_FINISH = 4'd7;

   logic [3:0]             state_ff, state_in;
   logic [DAY_W-1:0]       day_ff, day_in;
   logic [MONTH_W-1:0]     month_ff, month_in;
   logic [YEAR_BITS-1:0]   year_ff, year_in;
   logic [MOD_W-1:0]       mod_ff, mod_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DAY_W-1:0]       nd_ff, nd_in;
   logic [MONTH_W-1:0]     nm_ff, nm_in;
   logic [YEAR_BITS-1:0]   ny_ff, ny_in;
   logic                   bad_ff, bad_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in;

   logic [DAY_W-1:0]       def_day_ff;
   logic [MONTH_W-1:0]     def_month_ff;
   logic [YEAR_BITS-1:0]   def_year_ff;

   logic                   div_start;
   logic [DIV_W-1:0]       div_dividend;
   logic [DSR_W-1:0]       div_divisor;
   div_result_type         div_res;

   logic                   req_fire;
   logic [DAY_W-1:0]       set_d;
   logic [MONTH_W-1:0]     set_m;
   logic [YEAR_BITS-1:0]   set_y;
   logic [SUM_W-1:0]       years_sum;
   logic [DIV_W-1:0]       month_total;
   logic [SUM_W-1:0]       mdiv_sum;
   logic [YEAR_BITS:0]     cycle_sum;
   logic [DAY_W-1:0]       cur_len;
   logic [DAY_W-1:0]       div_len;
   logic                   div_leap;
   logic [CNT_W:0]         day_cnt_sum;
   logic [CNT_W-1:0]       month_step;
   logic [MOD_W-1:0]       div_mod;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // substitute defaults for zero fields of a set
   assign set_d = (req_data.day_in == '0)   ? def_day_ff   : req_data.day_in;
   assign set_m = (req_data.month_in == '0) ? def_month_ff : req_data.month_in;
   assign set_y = (req_data.year_in == '0)  ? def_year_ff  : req_data.year_in;

   assign years_sum   = SUM_W'(year_ff) + SUM_W'(req_data.amount);
   assign month_total = DIV_W'(month_ff - JANUARY) + DIV_W'(req_data.amount);
   assign mdiv_sum    = SUM_W'(year_ff) + SUM_W'(div_res.quotient);
   assign cycle_sum   = {1'b0, year_ff} + (YEAR_BITS + 1)'(CYCLE_YEARS);

   assign div_mod  = div_res.remainder[MOD_W-1:0];
   assign div_leap = is_leap(div_mod);
   assign cur_len  = month_len(month_ff, is_leap(mod_ff));
   assign div_len  = month_len(nm_ff, div_leap);

   assign day_cnt_sum = (CNT_W + 1)'(day_ff) + (CNT_W + 1)'(cnt_ff);
   assign month_step  = CNT_W'(cur_len) - CNT_W'(day_ff) + CNT_W'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      mod_in       = mod_ff;
      cnt_in       = cnt_ff;
      nd_in        = nd_ff;
      nm_in        = nm_ff;
      ny_in        = ny_ff;
      bad_in       = bad_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_dividend = DIV_W'(ny_ff);
      div_divisor  = DIVISOR_400;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               bad_in = 1'b0;
               ovf_in = 1'b0;
               cnt_in = CNT_W'(req_data.amount);
               if (req_data.req_type == REQ_SET) begin
                  nd_in = set_d;
                  nm_in = set_m;
                  ny_in = set_y;
                  if (set_y == '0 || set_m == '0 || set_m > DECEMBER || set_d == '0) begin
                     bad_in   = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = DIV_W'(set_y);
                     state_in     = ST_SETMOD;
                  end
               end else if (req_data.amount == '0) begin
                  state_in = ST_FINISH;
               end else if (req_data.req_type == REQ_DAYS) begin
                  state_in = ST_CYCLE;
               end else if (req_data.req_type == REQ_MONTHS) begin
                  div_start    = 1'b1;
                  div_dividend = month_total;
                  div_divisor  = DIVISOR_12;
                  state_in     = ST_MDIV;
               end else if (years_sum > SUM_W'(YEAR_MAX)) begin
                  ovf_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  ny_in        = years_sum[YEAR_BITS-1:0];
                  div_start    = 1'b1;
                  div_dividend = DIV_W'(years_sum[YEAR_BITS-1:0]);
                  state_in     = ST_YMOD;
               end
            end
         end
         // validate the set date once the leap year is known
         ST_SETMOD: begin
            if (div_res.done) begin
               if (nd_ff > div_len) begin
                  bad_in = 1'b1;
               end else begin
                  day_in   = nd_ff;
                  month_in = nm_ff;
                  year_in  = ny_ff;
                  mod_in   = div_mod;
               end
               state_in = ST_FINISH;
            end
         end
         // skip whole 400-year cycles
         ST_CYCLE: begin
            if (cnt_ff >= CYCLE_DAYS) begin
               if (cycle_sum > {1'b0, YEAR_MAX}) begin
                  ovf_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  year_in = cycle_sum[YEAR_BITS-1:0];
                  cnt_in  = cnt_ff - CYCLE_DAYS;
               end
            end else begin
               state_in = ST_MONTH;
            end
         end
         // walk one month per cycle
         ST_MONTH: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else if (day_cnt_sum <= (CNT_W + 1)'(cur_len)) begin
               day_in   = day_cnt_sum[DAY_W-1:0];
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff - month_step;
               day_in = DAY_W'(1);
               if (month_ff == DECEMBER) begin
                  if (year_ff == YEAR_MAX) begin
                     ovf_in   = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     month_in = JANUARY;
                     year_in  = year_ff + YEAR_BITS'(1);
                     mod_in   = mod_next(mod_ff);
                  end
               end else begin
                  month_in = month_ff + MONTH_W'(1);
               end
            end
         end
         // month total split into years and month, then mod 400 of new year
         ST_MDIV: begin
            if (div_res.done) begin
               if (mdiv_sum > SUM_W'(YEAR_MAX)) begin
                  ovf_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  ny_in        = mdiv_sum[YEAR_BITS-1:0];
                  nm_in        = MONTH_W'(div_res.remainder) + MONTH_W'(1);
                  div_start    = 1'b1;
                  div_dividend = DIV_W'(mdiv_sum[YEAR_BITS-1:0]);
                  state_in     = ST_MMOD;
               end
            end
         end
         // roll days beyond the new month's length into the next month
         ST_MMOD: begin
            if (div_res.done) begin
               state_in = ST_FINISH;
               if (day_ff > div_len) begin
                  day_in = day_ff - div_len;
                  if (nm_ff == DECEMBER) begin
                     if (ny_ff == YEAR_MAX) begin
                        ovf_in = 1'b1;
                     end else begin
                        month_in = JANUARY;
                        year_in  = ny_ff + YEAR_BITS'(1);
                        mod_in   = mod_next(div_mod);
                     end
                  end else begin
                     month_in = nm_ff + MONTH_W'(1);
                     year_in  = ny_ff;
                     mod_in   = div_mod;
                  end
               end else begin
                  month_in = nm_ff;
                  year_in  = ny_ff;
                  mod_in   = div_mod;
               end
            end
         end
         // move a leap day that lands in a common year
         ST_YMOD: begin
            if (div_res.done) begin
               year_in = ny_ff;
               mod_in  = div_mod;
               if (month_ff == FEBRUARY && day_ff == LEAP_DAY && !div_leap) begin
                  day_in   = DAY_W'(1);
                  month_in = MARCH;
               end
               state_in = ST_FINISH;
            end
         end
         // hold until the response register is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.day_out        = ovf_ff ? LAST_DAY : day_ff;
               rsp_in.month_out      = ovf_ff ? DECEMBER : month_ff;
               rsp_in.year_out       = ovf_ff ? YEAR_MAX : year_ff;
               rsp_in.bad_date       = bad_ff;
               rsp_in.year_overflow  = ovf_ff;
               if (ovf_ff) begin
                  day_in   = LAST_DAY;
                  month_in = DECEMBER;
                  year_in  = YEAR_MAX;
                  mod_in   = YEAR_MAX_MOD;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   gda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // date state and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         day_ff       <= RESET_DAY;
         month_ff     <= RESET_MONTH;
         year_ff      <= RESET_YEAR;
         mod_ff       <= RESET_MOD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff <= cnt_in;
      nd_ff  <= nd_in;
      nm_ff  <= nm_in;
      ny_ff  <= ny_in;
      bad_ff <= bad_in;
      ovf_ff <= ovf_in;
      rsp_ff <= rsp_in;
   end

   // default date registers
   always_ff @(posedge clock) begin
      if (reset) begin
         def_day_ff   <= RESET_DAY;
         def_month_ff <= RESET_MONTH;
         def_year_ff  <= RESET_YEAR;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEF_DAY:   def_day_ff   <= csr_wdata[DAY_W-1:0];
            CSR_DEF_MONTH: def_month_ff <= csr_wdata[MONTH_W-1:0];
            CSR_DEF_YEAR:  def_year_ff  <= csr_wdata[YEAR_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### dv/date_checker.sv
// ----------------------------------------------------------------------------
// date_checker: response checker for the Gregorian date arithmetic block
// Tracks the default date registers and the held date, predicts the response
// of every accepted request and compares it, field by field, with the oldest
// pending prediction when the response transaction is accepted.
// ----------------------------------------------------------------------------
module date_checker
   import gda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    backlog,
   output int                    checked_count,
   output int                    rejected_count,
   output int                    saturated_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned LAST_YEAR     = (64'd1 << YEAR_BITS) - 64'd1;
   localparam longint unsigned DAYS_PER_ERA  = 146097;
   localparam longint unsigned YEARS_PER_ERA = 400;
   localparam int              SHOW_LIMIT    = 10;

   // power-on date and defaults
   localparam longint unsigned POWER_ON_DAY   = 22;
   localparam longint unsigned POWER_ON_MONTH = 12;
   localparam longint unsigned POWER_ON_YEAR  = 2015;

   longint unsigned def_day, def_month, def_year;
   longint unsigned now_day, now_month, now_year;
   rsp_payload_type expected_dates[$];
   rsp_payload_type want;
   int              shown_mismatches = 0;

   function automatic bit leap_year(input longint unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic longint unsigned days_in(input longint unsigned m,
                                               input longint unsigned y);
      case (m)
         2:                       return leap_year(y) ? 29 : 28;
         4, 6, 9, 11:             return 30;
         1, 3, 5, 7, 8, 10, 12:   return 31;
         default:                 return 0;
      endcase
   endfunction

   // Apply one request to the held date and return the response it produces.
   function automatic rsp_payload_type apply_request(input req_payload_type r);
      longint unsigned d, m, y, n, len, total;
      bit              bad, ovf;
      rsp_payload_type res;
      d   = now_day;
      m   = now_month;
      y   = now_year;
      n   = r.amount;
      bad = 1'b0;
      ovf = 1'b0;
      case (r.req_type)
         REQ_SET: begin
            y   = (r.year_in == '0) ? def_year : r.year_in;
            m   = (r.month_in == '0) ? def_month : r.month_in;
            d   = (r.day_in == '0) ? def_day : r.day_in;
            len = days_in(m, y);
            bad = (y == 0) || (len == 0) || (d < 1) || (d > len);
         end
         REQ_DAYS: begin
            // skip whole 400-year eras first, then walk month by month
            while (!ovf && n >= DAYS_PER_ERA) begin
               if (y + YEARS_PER_ERA > LAST_YEAR) begin
                  ovf = 1'b1;
               end else begin
                  y += YEARS_PER_ERA;
                  n -= DAYS_PER_ERA;
               end
            end
            while (!ovf && n > 0) begin
               len = days_in(m, y);
               if (d + n <= len) begin
                  d += n;
                  n = 0;
               end else begin
                  n -= len - d + 1;
                  d = 1;
                  m++;
                  if (m > 12) begin
                     if (y >= LAST_YEAR) begin
                        ovf = 1'b1;
                     end else begin
                        m = 1;
                        y++;
                     end
                  end
               end
            end
         end
         REQ_MONTHS: begin
            if (n != 0) begin
               total = (now_month - 1) + n;
               y = now_year + total / 12;
               m = total % 12 + 1;
               if (y > LAST_YEAR) begin
                  ovf = 1'b1;
               end else begin
                  // roll days past the end of the new month forward
                  len = days_in(m, y);
                  if (d > len) begin
                     d -= len;
                     m++;
                     if (m > 12) begin
                        if (y >= LAST_YEAR) begin
                           ovf = 1'b1;
                        end else begin
                           m = 1;
                           y++;
                        end
                     end
                  end
               end
            end
         end
         default: begin
            if (n != 0) begin
               y = now_year + n;
               if (y > LAST_YEAR) begin
                  ovf = 1'b1;
               end else if (m == 2 && d == 29 && !leap_year(y)) begin
                  // leap day lands on a common year
                  d = 1;
                  m = 3;
               end
            end
         end
      endcase
      if (ovf) begin
         d = 31;
         m = 12;
         y = LAST_YEAR;
      end
      if (!bad) begin
         now_day   = d;
         now_month = m;
         now_year  = y;
      end
      res.day_out       = DAY_W'(now_day);
      res.month_out     = MONTH_W'(now_month);
      res.year_out      = YEAR_BITS'(now_year);
      res.bad_date      = bad;
      res.year_overflow = ovf;
      return res;
   endfunction

   // Track register writes, check responses, then queue new predictions.
   always @(posedge clock) begin
      if (reset) begin
         def_day   = POWER_ON_DAY;
         def_month = POWER_ON_MONTH;
         def_year  = POWER_ON_YEAR;
         now_day   = POWER_ON_DAY;
         now_month = POWER_ON_MONTH;
         now_year  = POWER_ON_YEAR;
         expected_dates.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEF_DAY:   def_day = csr_wdata[DAY_W-1:0];
               CSR_DEF_MONTH: def_month = csr_wdata[MONTH_W-1:0];
               CSR_DEF_YEAR:  def_year = csr_wdata[YEAR_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_dates.size() == 0) begin
               fail_count++;
               if (shown_mismatches < SHOW_LIMIT) begin
                  shown_mismatches++;
                  $display("%0t: response with nothing pending: %0d-%0d-%0d bad=%0b ovf=%0b",
                           $realtime, rsp_data.year_out, rsp_data.month_out,
                           rsp_data.day_out, rsp_data.bad_date, rsp_data.year_overflow);
               end
            end else begin
               want = expected_dates.pop_front();
               checked_count++;
               if (want.bad_date) rejected_count++;
               if (want.year_overflow) saturated_count++;
               if (rsp_data !== want) begin
                  fail_count++;
                  if (shown_mismatches < SHOW_LIMIT) begin
                     shown_mismatches++;
                     $display("%0t: date mismatch: expected %0d-%0d-%0d bad=%0b ovf=%0b",
                              $realtime, want.year_out, want.month_out, want.day_out,
                              want.bad_date, want.year_overflow);
                     $display("              actual   %0d-%0d-%0d bad=%0b ovf=%0b",
                              rsp_data.year_out, rsp_data.month_out, rsp_data.day_out,
                              rsp_data.bad_date, rsp_data.year_overflow);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_dates.push_back(apply_request(req_data));
         end
      end
      backlog <= expected_dates.size();
   end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the Gregorian date arithmetic block
// Drives directed and random set/add transactions under several default
// date settings with random stalls on both channels; the date checker
// predicts and compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench
   import gda_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PER_PHASE = 55;
   localparam int DRAIN_CYCLES     = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    backlog;
   int                    checked_count;
   int                    rejected_count;
   int                    saturated_count;
   int                    sent_count = 0;
   bit                    steady_flow = 1'b0;

   gregorian_date_arithmetic u_dut (.*);
   date_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the response side at random unless in a steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= 12);
   end

   function automatic req_payload_type date_request(input logic [1:0] kind,
                                                    input int unsigned d, m, y, n);
      req_payload_type r;
      r.req_type = kind;
      r.day_in   = DAY_W'(d);
      r.month_in = MONTH_W'(m);
      r.year_in  = YEAR_BITS'(y);
      r.amount   = AMOUNT_BITS'(n);
      return r;
   endfunction

   // Mostly plausible dates and short moves, with rare full-range values.
   function automatic req_payload_type random_request();
      int unsigned     pick;
      req_payload_type r;
      pick = $urandom_range(99);
      r = date_request(REQ_SET, $urandom_range(31), $urandom_range(15), $urandom, $urandom);
      if (pick < 30) begin
         if ($urandom_range(9) < 7) begin
            r.day_in   = DAY_W'($urandom_range(1, 28));
            r.month_in = MONTH_W'($urandom_range(1, 12));
         end
         if ($urandom_range(3) != 0) r.year_in = YEAR_BITS'($urandom_range(1, 2500));
         if ($urandom_range(5) == 0) r.year_in = '0;
         if ($urandom_range(7) == 0) begin
            r.day_in   = LEAP_DAY;
            r.month_in = FEBRUARY;
            r.year_in  = YEAR_BITS'(4 * $urandom_range(1, 600));
         end
      end else if (pick < 55) begin
         r.req_type = REQ_DAYS;
         if ($urandom_range(15) != 0) r.amount = AMOUNT_BITS'($urandom_range(1500));
      end else if (pick < 80) begin
         r.req_type = REQ_MONTHS;
         if ($urandom_range(7) != 0) r.amount = AMOUNT_BITS'($urandom_range(60));
      end else begin
         r.req_type = REQ_YEARS;
         if ($urandom_range(7) != 0) r.amount = AMOUNT_BITS'($urandom_range(400));
      end
      return r;
   endfunction

   // Present one transaction, idling first at random, and hold until taken.
   task automatic send_request(input req_payload_type item);
      while (!steady_flow && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Drop valid and wait until every pending response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_defaults(input int unsigned d, m, y);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEF_DAY;
      csr_wdata <= CSR_DATA_W'(d);
      @(posedge clock);
      csr_index <= CSR_DEF_MONTH;
      csr_wdata <= CSR_DATA_W'(m);
      @(posedge clock);
      csr_index <= CSR_DEF_YEAR;
      csr_wdata <= CSR_DATA_W'(y);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_request(random_request());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on defaults: directed corners
      send_request(date_request(REQ_SET, 0, 0, 0, 0));
      send_request(date_request(REQ_SET, 29, 2, 2000, 0));
      send_request(date_request(REQ_YEARS, 0, 0, 0, 1));
      send_request(date_request(REQ_SET, 29, 2, 1900, 0));
      send_request(date_request(REQ_SET, 29, 2, 2024, 0));
      send_request(date_request(REQ_YEARS, 0, 0, 0, 4));
      send_request(date_request(REQ_SET, 31, 4, 2020, 0));
      send_request(date_request(REQ_SET, 5, 13, 2020, 0));
      send_request(date_request(REQ_SET, 5, 15, 2020, 0));
      send_request(date_request(REQ_SET, 31, 1, 2021, 0));
      send_request(date_request(REQ_MONTHS, 0, 0, 0, 1));
      send_request(date_request(REQ_SET, 31, 1, 2024, 0));
      send_request(date_request(REQ_MONTHS, 0, 0, 0, 1));
      send_request(date_request(REQ_DAYS, 31, 15, 65535, 0));
      send_request(date_request(REQ_MONTHS, 0, 0, 0, 0));
      send_request(date_request(REQ_YEARS, 0, 0, 0, 0));
      send_request(date_request(REQ_SET, 31, 12, 2023, 0));
      send_request(date_request(REQ_DAYS, 0, 0, 0, 1));
      send_request(date_request(REQ_DAYS, 0, 0, 0, 65535));
      send_request(date_request(REQ_SET, 31, 12, 65535, 0));
      send_request(date_request(REQ_DAYS, 0, 0, 0, 1));
      send_request(date_request(REQ_SET, 1, 1, 65000, 0));
      send_request(date_request(REQ_YEARS, 0, 0, 0, 65535));
      send_request(date_request(REQ_SET, 15, 6, 1, 0));
      send_request(date_request(REQ_MONTHS, 0, 0, 0, 65535));
      send_random(RANDOM_PER_PHASE);

      // last day and year as defaults, February as default month
      wait_idle();
      program_defaults(31, 2, 65535);
      send_request(date_request(REQ_SET, 0, 0, 0, 0));
      send_request(date_request(REQ_SET, 28, 0, 0, 0));
      send_request(date_request(REQ_SET, 0, 1, 0, 0));
      send_random(RANDOM_PER_PHASE);

      // earliest defaults, run without any idling
      wait_idle();
      program_defaults(1, 1, 1);
      steady_flow <= 1'b1;
      send_request(date_request(REQ_SET, 0, 0, 0, 0));
      send_random(RANDOM_PER_PHASE);

      // random defaults
      wait_idle();
      steady_flow <= 1'b0;
      program_defaults($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, 65535));
      send_request(date_request(REQ_SET, 0, 0, 0, 0));
      send_random(RANDOM_PER_PHASE);

      // drain and give the verdict
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions under four default settings; %0d responses checked.",
               sent_count, checked_count);
      $display("Of those, %0d sets were rejected and %0d adds saturated at the last year.",
               rejected_count, saturated_count);
      if (fail_count == 0 && backlog == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hard stop in case the block hangs
   initial begin
      #30_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### gregorian_date_arithmetic.f
rtl/gda_pkg.sv
rtl/gda_div.sv
rtl/gregorian_date_arithmetic.sv
dv/date_checker.sv
dv/testbench.sv
